@@ design/lzbr_pkg.sv @@
// ----------------------------------------------------------------------------
// lzbr_pkg
// Shared types and constants of the back-reference decompressor.
// ----------------------------------------------------------------------------
package lzbr_pkg;

  localparam int HistDepth = 256;
  localparam int HistAw    = $clog2(HistDepth);

  // beat status codes
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_BAD_OFFSET    = 2'd1;
  localparam logic [1:0] ST_TRUNCATED     = 2'd2;
  localparam logic [1:0] ST_SIZE_MISMATCH = 2'd3;

  // beat data sources
  localparam logic [1:0] BEAT_EMPTY = 2'd0;
  localparam logic [1:0] BEAT_LIT   = 2'd1;
  localparam logic [1:0] BEAT_COPY  = 2'd2;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic [1:0] byte_count;
    logic [1:0] status;
    logic       stream_end;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic       ld_size_lo;
    logic       ld_size_hi;
    logic       ld_lit;
    logic       ld_copy;
    logic       ld_off;
    logic       put_lit;
    logic       rd_hist;
    logic       put_copy;
    logic       new_stream;
    logic       emit;
    logic [1:0] beat_sel;
    logic [1:0] status;
    logic       stream_end;
    logic       run_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_last;
    logic in_copy;
    logic in_zero;
    logic lit_done;
    logic size_ok;
    logic size_ok_inc;
    logic size_ok_hi;
    logic off_bad;
    logic copy_zero;
    logic copy_last;
    logic pend_full;
  } stat_t;

endpackage

@@ design/lzbr_datapath.sv @@
// ----------------------------------------------------------------------------
// lzbr_datapath
// Stream counters, history memory, byte pairing and the output register.
// ----------------------------------------------------------------------------
module lzbr_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lzbr_pkg::in_item_t  item,
  input  lzbr_pkg::cmd_t      cmd,
  output lzbr_pkg::stat_t     stat,
  output logic                out_valid,
  input  logic                out_ready,
  output lzbr_pkg::out_item_t out_item
);

  logic [7:0]                  mem [lzbr_pkg::HistDepth];
  logic [15:0]                 expected_size;
  logic [6:0]                  literal_left;
  logic [6:0]                  copy_left;
  logic [15:0]                 produced_count;
  logic [7:0]                  produced_sat;
  logic [lzbr_pkg::HistAw-1:0] hist_ptr;
  logic [7:0]                  offset;
  logic [7:0]                  pend_byte;
  logic                        pend_full;
  logic [7:0]                  rd_data;

  logic [7:0]                  b;
  logic                        wr_en;
  logic [7:0]                  wr_byte;
  logic [lzbr_pkg::HistAw-1:0] rd_addr;
  lzbr_pkg::out_item_t         beat;

  assign b       = item.packed_byte;
  assign wr_en   = cmd.put_lit | cmd.put_copy;
  assign wr_byte = cmd.put_lit ? b : rd_data;
  assign rd_addr = hist_ptr - lzbr_pkg::HistAw'(offset);

  assign stat.out_free    = !out_valid || out_ready;
  assign stat.in_last     = item.last_byte;
  assign stat.in_copy     = b[7];
  assign stat.in_zero     = (b == 8'd0);
  assign stat.lit_done    = (literal_left == 7'd1);
  assign stat.size_ok     = (expected_size == produced_count);
  assign stat.size_ok_inc = (expected_size == produced_count + 16'd1);
  assign stat.size_ok_hi  = ({b, expected_size[7:0]} == produced_count);
  assign stat.off_bad     = (b == 8'd0) || (b > produced_sat);
  assign stat.copy_zero   = (copy_left == 7'd0);
  assign stat.copy_last   = (copy_left == 7'd1);
  assign stat.pend_full   = pend_full;

  always_comb begin
    beat             = '0;
    beat.status      = cmd.status;
    beat.stream_end  = cmd.stream_end;
    beat.run_last    = cmd.run_last;
    case (cmd.beat_sel)
      lzbr_pkg::BEAT_LIT: begin
        beat.data_first = b;
        beat.byte_count = 2'd1;
      end
      lzbr_pkg::BEAT_COPY: begin
        if (pend_full) begin
          beat.data_first  = pend_byte;
          beat.data_second = rd_data;
          beat.byte_count  = 2'd2;
        end else begin
          beat.data_first  = rd_data;
          beat.byte_count  = 2'd1;
        end
      end
      default: beat.byte_count = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size  <= '0;
      literal_left   <= '0;
      copy_left      <= '0;
      produced_count <= '0;
      produced_sat   <= '0;
      hist_ptr       <= '0;
      offset         <= '0;
      pend_full      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.ld_off) offset <= b;
      if (cmd.new_stream) begin
        expected_size  <= '0;
        literal_left   <= '0;
        copy_left      <= '0;
        produced_count <= '0;
        produced_sat   <= '0;
        hist_ptr       <= '0;
        pend_full      <= 1'b0;
      end else begin
        if (cmd.ld_size_lo) expected_size[7:0]  <= b;
        if (cmd.ld_size_hi) expected_size[15:8] <= b;
        if (cmd.ld_lit) literal_left <= b[6:0];
        else if (cmd.put_lit) literal_left <= literal_left - 7'd1;
        if (cmd.ld_copy) copy_left <= b[6:0];
        else if (cmd.put_copy) copy_left <= copy_left - 7'd1;
        if (wr_en) begin
          produced_count <= produced_count + 16'd1;
          hist_ptr       <= hist_ptr + 1'b1;
          if (produced_sat != 8'hff) produced_sat <= produced_sat + 8'd1;
        end
        if (cmd.put_copy) pend_full <= !cmd.emit;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[hist_ptr] <= wr_byte;
    if (cmd.rd_hist) rd_data <= mem[rd_addr];
    if (cmd.put_copy && !cmd.emit) pend_byte <= rd_data;
    if (cmd.emit) out_item <= beat;
  end

endmodule

@@ design/lzbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// lzbr_ctrl
// Stream parser and copy sequencer of the back-reference decompressor.
// ----------------------------------------------------------------------------
module lzbr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lzbr_pkg::stat_t stat,
  output lzbr_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_SIZE_LO = 3'd0;
  localparam logic [2:0] S_SIZE_HI = 3'd1;
  localparam logic [2:0] S_CONTROL = 3'd2;
  localparam logic [2:0] S_LITERAL = 3'd3;
  localparam logic [2:0] S_OFFSET  = 3'd4;
  localparam logic [2:0] S_DRAIN   = 3'd5;
  localparam logic [2:0] S_COPY_RD = 3'd6;
  localparam logic [2:0] S_COPY_WR = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last_q;
  logic       last_next;
  logic       accept;
  logic       need_emit;

  always_comb begin
    in_ready = stat.out_free &&
               (state inside {S_SIZE_LO, S_SIZE_HI, S_CONTROL, S_LITERAL, S_OFFSET, S_DRAIN});
  end

  assign accept    = in_valid && in_ready;
  assign need_emit = stat.pend_full || stat.copy_last;

  always_comb begin
    cmd        = '0;
    state_next = state;
    last_next  = last_q;
    case (state)
      S_SIZE_LO: begin
        if (accept) begin
          cmd.ld_size_lo = 1'b1;
          state_next     = S_SIZE_HI;
          if (stat.in_last) begin
            cmd.emit       = 1'b1;
            cmd.status     = lzbr_pkg::ST_TRUNCATED;
            cmd.stream_end = 1'b1;
            cmd.run_last   = 1'b1;
            cmd.new_stream = 1'b1;
            state_next     = S_SIZE_LO;
          end
        end
      end
      S_SIZE_HI: begin
        if (accept) begin
          cmd.ld_size_hi = 1'b1;
          state_next     = S_CONTROL;
          if (stat.in_last) begin
            cmd.emit       = 1'b1;
            cmd.status     = stat.size_ok_hi ? lzbr_pkg::ST_OK : lzbr_pkg::ST_SIZE_MISMATCH;
            cmd.stream_end = 1'b1;
            cmd.run_last   = 1'b1;
            cmd.new_stream = 1'b1;
            state_next     = S_SIZE_LO;
          end
        end
      end
      S_CONTROL: begin
        if (accept) begin
          if (stat.in_copy) begin
            cmd.ld_copy = 1'b1;
            state_next  = S_OFFSET;
          end else begin
            cmd.ld_lit = 1'b1;
            state_next = stat.in_zero ? S_CONTROL : S_LITERAL;
          end
          if (stat.in_last) begin
            cmd.emit       = 1'b1;
            cmd.stream_end = 1'b1;
            cmd.run_last   = 1'b1;
            cmd.new_stream = 1'b1;
            state_next     = S_SIZE_LO;
            if (!stat.in_copy && stat.in_zero) begin
              cmd.status = stat.size_ok ? lzbr_pkg::ST_OK : lzbr_pkg::ST_SIZE_MISMATCH;
            end else begin
              cmd.status = lzbr_pkg::ST_TRUNCATED;
            end
          end
        end
      end
      S_LITERAL: begin
        if (accept) begin
          cmd.put_lit  = 1'b1;
          cmd.emit     = 1'b1;
          cmd.beat_sel = lzbr_pkg::BEAT_LIT;
          cmd.run_last = 1'b1;
          state_next   = stat.lit_done ? S_CONTROL : S_LITERAL;
          if (stat.in_last) begin
            cmd.stream_end = 1'b1;
            cmd.new_stream = 1'b1;
            state_next     = S_SIZE_LO;
            if (stat.lit_done) begin
              cmd.status = stat.size_ok_inc ? lzbr_pkg::ST_OK : lzbr_pkg::ST_SIZE_MISMATCH;
            end else begin
              cmd.status = lzbr_pkg::ST_TRUNCATED;
            end
          end
        end
      end
      S_OFFSET: begin
        if (accept) begin
          if (stat.off_bad) begin
            cmd.emit       = 1'b1;
            cmd.status     = lzbr_pkg::ST_BAD_OFFSET;
            cmd.stream_end = 1'b1;
            cmd.run_last   = 1'b1;
            if (stat.in_last) begin
              cmd.new_stream = 1'b1;
              state_next     = S_SIZE_LO;
            end else begin
              state_next = S_DRAIN;
            end
          end else begin
            cmd.ld_off = 1'b1;
            last_next  = stat.in_last;
            if (!stat.copy_zero) begin
              state_next = S_COPY_RD;
            end else if (stat.in_last) begin
              cmd.emit       = 1'b1;
              cmd.status     = stat.size_ok ? lzbr_pkg::ST_OK : lzbr_pkg::ST_SIZE_MISMATCH;
              cmd.stream_end = 1'b1;
              cmd.run_last   = 1'b1;
              cmd.new_stream = 1'b1;
              state_next     = S_SIZE_LO;
            end else begin
              state_next = S_CONTROL;
            end
          end
        end
      end
      S_DRAIN: begin
        // input after an error is dropped up to the end of the stream
        if (accept && stat.in_last) begin
          cmd.new_stream = 1'b1;
          state_next     = S_SIZE_LO;
        end
      end
      S_COPY_RD: begin
        cmd.rd_hist = 1'b1;
        state_next  = S_COPY_WR;
      end
      S_COPY_WR: begin
        if (!need_emit || stat.out_free) begin
          cmd.put_copy = 1'b1;
          state_next   = S_COPY_RD;
          if (need_emit) begin
            cmd.emit     = 1'b1;
            cmd.beat_sel = lzbr_pkg::BEAT_COPY;
            cmd.run_last = stat.copy_last;
          end
          if (stat.copy_last) begin
            state_next = S_CONTROL;
            if (last_q) begin
              cmd.status     = stat.size_ok_inc ? lzbr_pkg::ST_OK : lzbr_pkg::ST_SIZE_MISMATCH;
              cmd.stream_end = 1'b1;
              cmd.new_stream = 1'b1;
              state_next     = S_SIZE_LO;
            end
          end
        end
      end
      default: state_next = S_SIZE_LO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_SIZE_LO;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      last_q <= last_next;
    end
  end

endmodule

@@ design/lz_backref_decompressor.sv @@
// ----------------------------------------------------------------------------
// lz_backref_decompressor
// Unpacks a stream of literal runs and back-references into data beats.
// ----------------------------------------------------------------------------
// Input channel (packed_valid/packed_ready/packed_item): one packed byte per
// beat, last_byte marks the end of a stream. Stream layout: two size bytes (low
// first), then commands: a control below 0x80 followed by that many literals,
// or 0x80+n followed by an offset byte that copies n bytes from the history.
// Output channel (unpacked_valid/unpacked_ready/unpacked): beats of up to two
// bytes; the final beat of a stream has stream_end set and carries the status.
// Throughput: size, control, offset and literal bytes are taken one per cycle
// while no copy runs and the output register is free; a beat appears in the
// output register the cycle after the byte is taken. A copy holds the input
// until its last byte is written, plus stalls: the history is a single
// memory with a registered read, so each copied byte is read, then written.
// A stalled receiver holds the output register; input is taken only when the
// output register is free or being emptied in the same cycle.
// Reset returns the parser to the first size byte; the history memory is not
// cleared and needs no clearing pass, so input is taken right after reset.
// ----------------------------------------------------------------------------
module lz_backref_decompressor (
  input  logic                clk,
  input  logic                rst,
  input  logic                packed_valid,
  output logic                packed_ready,
  input  lzbr_pkg::in_item_t  packed_item,
  output logic                unpacked_valid,
  input  logic                unpacked_ready,
  output lzbr_pkg::out_item_t unpacked
);

  lzbr_pkg::cmd_t  cmd;
  lzbr_pkg::stat_t stat;

  lzbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (packed_valid),
    .in_ready (packed_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzbr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (packed_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (unpacked_valid),
    .out_ready (unpacked_ready),
    .out_item  (unpacked)
  );

  // a nonzero status only ever rides on the final beat of a stream
  assert property (@(posedge clk) disable iff (rst)
    unpacked_valid && (unpacked.status != lzbr_pkg::ST_OK) |-> unpacked.stream_end)
    else $error("status on a beat that does not end the stream");

  assert property (@(posedge clk) disable iff (rst)
    unpacked_valid && unpacked.stream_end |-> unpacked.run_last)
    else $error("stream end without run_last");

  assert property (@(posedge clk) disable iff (rst)
    unpacked_valid |-> (unpacked.byte_count != 2'd3))
    else $error("illegal byte count");

  // a new beat is loaded only into a free output register
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("beat loaded over a stalled beat");

endmodule
